FILE: hw/rtl/cbc_pkg.sv
// Shared types and constants for the circle/box contact tester.
// Depends on nothing; cbc_dsu and circle_box_contact_top import it.
package cbc_pkg;

  localparam int CoordW = 32;
  localparam int RadW   = 31;

  // Step counts of the iterative divide/square-root unit.
  localparam logic [5:0]  TSteps    = 6'd31;
  localparam logic [5:0]  MdSteps   = 6'd34;
  localparam logic [5:0]  SqrtSteps = 6'd31;
  localparam logic [63:0] SqrtBit0  = 64'h1000_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CORNER = 2'd1,
    KIND_EDGE   = 2'd2
  } hit_kind_e;

  typedef enum logic {
    DSU_DIV,
    DSU_SQRT
  } dsu_mode_e;

  typedef struct packed {
    logic        start;
    dsu_mode_e   mode;
    logic [63:0] rem0;
    logic [63:0] den;
    logic [33:0] bits;
    logic [5:0]  steps;
  } dsu_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RSQ, ST_RCAP, ST_EDGE, ST_W1, ST_W2, ST_W3, ST_D1, ST_D2,
    ST_L1, ST_L2, ST_TDIV, ST_F1, ST_F2, ST_F3, ST_Q1, ST_Q2, ST_Q3,
    ST_SQRT, ST_MD_MUL, ST_MD_DIV, ST_MD_WAIT
  } cbc_state_e;

endpackage

FILE: hw/rtl/cbc_mul.sv
// Registered 33x33 signed multiplier shared by all products of the tester.
// No dependencies.
module cbc_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: hw/rtl/cbc_dsu.sv
// Iterative shift-subtract unit: restoring division or integer square root,
// one bit per cycle through a single 64-bit compare/subtract. Uses cbc_pkg.
module cbc_dsu import cbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dsu_cmd_t    cmd_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  dsu_mode_e   mode_q;
  logic [63:0] rem_q, den_q, quo_q;
  logic [33:0] bits_q;

  logic [63:0] div_a, sq_b, cmp_a, cmp_b, diff;
  logic        ge;

  // In square-root mode rem holds the remaining value and den the probe bit.
  assign div_a = {rem_q[62:0], bits_q[33]};
  assign sq_b  = quo_q + den_q;
  assign cmp_a = (mode_q == DSU_DIV) ? div_a : rem_q;
  assign cmp_b = (mode_q == DSU_DIV) ? den_q : sq_b;
  assign ge    = cmp_a >= cmp_b;
  assign diff  = cmp_a - cmp_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q <= cmd_i.mode;
      rem_q  <= cmd_i.rem0;
      den_q  <= cmd_i.den;
      bits_q <= cmd_i.bits;
      quo_q  <= '0;
    end else if (busy_q) begin
      if (mode_q == DSU_DIV) begin
        rem_q  <= ge ? diff : div_a;
        quo_q  <= {quo_q[62:0], ge};
        bits_q <= {bits_q[32:0], 1'b0};
      end else begin
        if (ge) begin
          rem_q <= diff;
          quo_q <= (quo_q >> 1) + den_q;
        end else begin
          quo_q <= quo_q >> 1;
        end
        den_q <= den_q >> 2;
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hw/rtl/circle_box_contact_top.sv
// Circle/box contact tester: sequencer and datapath around one multiplier
// and one divide/square-root unit. Uses cbc_pkg, cbc_mul and cbc_dsu.
//
// One test is taken when start is high and busy is low; busy then stays
// high until the result has been produced. The result appears for exactly
// one cycle with done_o high and must be captured in that cycle. A test
// does a setup step and then, per edge walked, the corner test and the
// projection; an edge whose projection falls inside adds a fraction divide
// (skipped when the center projects exactly onto the far corner) and the
// foot point. An edge hit adds a square root and a multiply and divide for
// each of the two normal and (for a movable circle) two push components.
// The worst case is set by the bit-serial divide/square-root unit.
module circle_box_contact_top import cbc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic        [RadW-1:0]   circle_radius_i,
  input  logic signed [CoordW-1:0] corner0_x_i,
  input  logic signed [CoordW-1:0] corner0_y_i,
  input  logic signed [CoordW-1:0] corner1_x_i,
  input  logic signed [CoordW-1:0] corner1_y_i,
  input  logic signed [CoordW-1:0] corner2_x_i,
  input  logic signed [CoordW-1:0] corner2_y_i,
  input  logic signed [CoordW-1:0] corner3_x_i,
  input  logic signed [CoordW-1:0] corner3_y_i,
  input  logic                     circle_immovable_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic [1:0]               hit_kind_o,
  output logic signed [CoordW-1:0] contact_x_o,
  output logic signed [CoordW-1:0] contact_y_o,
  output logic signed [CoordW-1:0] normal_x_o,
  output logic signed [CoordW-1:0] normal_y_o,
  output logic signed [CoordW-1:0] push_x_o,
  output logic signed [CoordW-1:0] push_y_o
);

  function automatic logic signed [31:0] sat_sym(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x > 33'sd2147483647) r = 32'sh7fff_ffff;
    else if (x < -33'sd2147483647) r = 32'sh8000_0001;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sd2147483647) r = 32'sh7fff_ffff;
    else if (x < -34'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [32:0] mag33(input logic signed [31:0] x);
    logic signed [32:0] v;
    v = {x[31], x};
    return x[31] ? -v : v;
  endfunction

  cbc_state_e state_q, state_d;

  logic [1:0]                k_q, j_q;
  logic signed [CoordW-1:0]  cx_q, cy_q;
  logic [RadW-1:0]           r_q;
  logic signed [CoordW-1:0]  vx_q [4];
  logic signed [CoordW-1:0]  vy_q [4];
  logic                      imm_q;
  logic [63:0]               r2_q, acc_q;
  logic signed [63:0]        dot_q;
  logic signed [31:0]        ex_q, ey_q, wx_q, wy_q, qx_q, qy_q, e2x_q, e2y_q;
  logic [31:0]               t_q;
  logic [RadW-1:0]           len_q;

  logic                      done_q, hit_q;
  hit_kind_e                 kind_q;
  logic signed [CoordW-1:0]  cox_q, coy_q, nox_q, noy_q, pux_q, puy_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [63:0]        p64, sum_c, num_c;
  logic               corner_hit, proj_ok, dot_eq, edge_hit, last_md;
  logic signed [31:0] ex_c, ey_c, wx_c, wy_c, q_sel, e2_c, q_c, md_val;
  logic [63:0]        scaled_c;
  logic [RadW-1:0]    gap_c;
  logic signed [31:0] ref_e, ref_w;

  dsu_cmd_t    dsu_cmd;
  logic        dsu_busy, dsu_done;
  logic [63:0] dsu_quo;

  cbc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  cbc_dsu u_dsu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (dsu_cmd),
    .busy_o (dsu_busy),
    .done_o (dsu_done),
    .quo_o  (dsu_quo)
  );

  // Corners rotate after each edge, so slot 0 is always the current corner
  // and slot 1 the far end of the current edge.
  assign ex_c = sat_sym({vx_q[1][31], vx_q[1]} - {vx_q[0][31], vx_q[0]});
  assign ey_c = sat_sym({vy_q[1][31], vy_q[1]} - {vy_q[0][31], vy_q[0]});
  assign wx_c = sat_sym({cx_q[31], cx_q} - {vx_q[0][31], vx_q[0]});
  assign wy_c = sat_sym({cy_q[31], cy_q} - {vy_q[0][31], vy_q[0]});

  assign p64   = mul_p[63:0];
  assign sum_c = acc_q + p64;
  assign corner_hit = sum_c < r2_q;
  assign proj_ok    = (dot_q > 64'sd0) && ($unsigned(dot_q) <= sum_c);
  assign dot_eq     = $unsigned(dot_q) == sum_c;
  assign edge_hit   = sum_c < r2_q;

  // Foot offset: edge component times the Q1.31 fraction, rounded half away.
  assign ref_e    = (state_q == ST_F2) ? ex_q : ey_q;
  assign ref_w    = (state_q == ST_F2) ? wx_q : wy_q;
  assign scaled_c = p64 + 64'h4000_0000;
  assign e2_c     = ref_e[31] ? -$signed(scaled_c[62:31]) : $signed(scaled_c[62:31]);
  assign q_c      = sat_sym({ref_w[31], ref_w} - {e2_c[31], e2_c});

  assign q_sel   = j_q[0] ? qy_q : qx_q;
  assign gap_c   = r_q - len_q;
  assign num_c   = p64 + {34'd0, len_q[RadW-1:1]};
  assign md_val  = q_sel[31] ? -$signed(dsu_quo[31:0]) : $signed(dsu_quo[31:0]);
  assign last_md = (j_q == 2'd3) || ((j_q == 2'd1) && imm_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_RSQ: begin
        mul_a = {2'b00, r_q};
        mul_b = {2'b00, r_q};
      end
      ST_W1: begin
        mul_a = {wx_q[31], wx_q};
        mul_b = {wx_q[31], wx_q};
      end
      ST_W2: begin
        mul_a = {wy_q[31], wy_q};
        mul_b = {wy_q[31], wy_q};
      end
      ST_W3: begin
        mul_a = {wx_q[31], wx_q};
        mul_b = {ex_q[31], ex_q};
      end
      ST_D1: begin
        mul_a = {wy_q[31], wy_q};
        mul_b = {ey_q[31], ey_q};
      end
      ST_D2: begin
        mul_a = {ex_q[31], ex_q};
        mul_b = {ex_q[31], ex_q};
      end
      ST_L1: begin
        mul_a = {ey_q[31], ey_q};
        mul_b = {ey_q[31], ey_q};
      end
      ST_F1: begin
        mul_a = mag33(ex_q);
        mul_b = {1'b0, t_q};
      end
      ST_F2: begin
        mul_a = mag33(ey_q);
        mul_b = {1'b0, t_q};
      end
      ST_Q1: begin
        mul_a = {qx_q[31], qx_q};
        mul_b = {qx_q[31], qx_q};
      end
      ST_Q2: begin
        mul_a = {qy_q[31], qy_q};
        mul_b = {qy_q[31], qy_q};
      end
      ST_MD_MUL: begin
        mul_a = mag33(q_sel);
        mul_b = j_q[1] ? {2'b00, gap_c} : 33'sd65536;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d       = state_q;
    dsu_cmd       = '0;
    dsu_cmd.mode  = DSU_DIV;
    case (state_q)
      ST_IDLE:  if (start) state_d = ST_RSQ;
      ST_RSQ:   state_d = ST_RCAP;
      ST_RCAP:  state_d = ST_EDGE;
      ST_EDGE:  state_d = ST_W1;
      ST_W1:    state_d = ST_W2;
      ST_W2:    state_d = ST_W3;
      ST_W3:    state_d = corner_hit ? ST_IDLE : ST_D1;
      ST_D1:    state_d = ST_D2;
      ST_D2:    state_d = ST_L1;
      ST_L1:    state_d = ST_L2;
      ST_L2: begin
        if (!proj_ok) begin
          state_d = (k_q == 2'd3) ? ST_IDLE : ST_EDGE;
        end else if (dot_eq) begin
          state_d = ST_F1;
        end else begin
          dsu_cmd.start = 1'b1;
          dsu_cmd.rem0  = dot_q;
          dsu_cmd.den   = sum_c;
          dsu_cmd.steps = TSteps;
          state_d       = ST_TDIV;
        end
      end
      ST_TDIV:  if (dsu_done) state_d = ST_F1;
      ST_F1:    state_d = ST_F2;
      ST_F2:    state_d = ST_F3;
      ST_F3:    state_d = ST_Q1;
      ST_Q1:    state_d = ST_Q2;
      ST_Q2:    state_d = ST_Q3;
      ST_Q3: begin
        if (edge_hit) begin
          dsu_cmd.start = 1'b1;
          dsu_cmd.mode  = DSU_SQRT;
          dsu_cmd.rem0  = sum_c;
          dsu_cmd.den   = SqrtBit0;
          dsu_cmd.steps = SqrtSteps;
          state_d       = ST_SQRT;
        end else begin
          state_d = (k_q == 2'd3) ? ST_IDLE : ST_EDGE;
        end
      end
      ST_SQRT: begin
        if (dsu_done) state_d = (dsu_quo[RadW-1:0] == '0) ? ST_IDLE : ST_MD_MUL;
      end
      ST_MD_MUL: state_d = ST_MD_DIV;
      ST_MD_DIV: begin
        dsu_cmd.start = 1'b1;
        dsu_cmd.rem0  = {34'd0, num_c[63:34]};
        dsu_cmd.den   = {33'd0, len_q};
        dsu_cmd.bits  = num_c[33:0];
        dsu_cmd.steps = MdSteps;
        state_d       = ST_MD_WAIT;
      end
      ST_MD_WAIT: begin
        if (dsu_done) state_d = last_md ? ST_IDLE : ST_MD_MUL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q != ST_IDLE) && (state_d == ST_IDLE);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cx_q    <= center_x_i;
          cy_q    <= center_y_i;
          r_q     <= circle_radius_i;
          imm_q   <= circle_immovable_i;
          vx_q[0] <= corner0_x_i;
          vy_q[0] <= corner0_y_i;
          vx_q[1] <= corner1_x_i;
          vy_q[1] <= corner1_y_i;
          vx_q[2] <= corner2_x_i;
          vy_q[2] <= corner2_y_i;
          vx_q[3] <= corner3_x_i;
          vy_q[3] <= corner3_y_i;
          k_q     <= 2'd0;
          hit_q   <= 1'b0;
          kind_q  <= KIND_NONE;
          cox_q   <= '0;
          coy_q   <= '0;
          nox_q   <= '0;
          noy_q   <= '0;
          pux_q   <= '0;
          puy_q   <= '0;
        end
      end
      ST_RCAP: r2_q <= p64;
      ST_EDGE: begin
        ex_q <= ex_c;
        ey_q <= ey_c;
        wx_q <= wx_c;
        wy_q <= wy_c;
      end
      ST_W2: acc_q <= p64;
      ST_W3: begin
        if (corner_hit) begin
          hit_q  <= 1'b1;
          kind_q <= KIND_CORNER;
          cox_q  <= vx_q[0];
          coy_q  <= vy_q[0];
          nox_q  <= wx_q;
          noy_q  <= wy_q;
        end
      end
      ST_D1: dot_q <= $signed(p64);
      ST_D2: dot_q <= dot_q + $signed(p64);
      ST_L1: acc_q <= p64;
      ST_L2: begin
        t_q  <= 32'h8000_0000;
        if (!proj_ok) begin
          for (int i = 0; i < 4; i++) begin
            vx_q[i] <= vx_q[(i + 1) % 4];
            vy_q[i] <= vy_q[(i + 1) % 4];
          end
          k_q <= k_q + 2'd1;
        end
      end
      ST_TDIV: if (dsu_done) t_q <= dsu_quo[31:0];
      ST_F2: begin
        e2x_q <= e2_c;
        qx_q  <= q_c;
      end
      ST_F3: begin
        e2y_q <= e2_c;
        qy_q  <= q_c;
      end
      ST_Q2: acc_q <= p64;
      ST_Q3: begin
        if (edge_hit) begin
          hit_q  <= 1'b1;
          kind_q <= KIND_EDGE;
          cox_q  <= sat32({{2{vx_q[0][31]}}, vx_q[0]} + {{2{e2x_q[31]}}, e2x_q});
          coy_q  <= sat32({{2{vy_q[0][31]}}, vy_q[0]} + {{2{e2y_q[31]}}, e2y_q});
        end else begin
          for (int i = 0; i < 4; i++) begin
            vx_q[i] <= vx_q[(i + 1) % 4];
            vy_q[i] <= vy_q[(i + 1) % 4];
          end
          k_q <= k_q + 2'd1;
        end
      end
      ST_SQRT: begin
        if (dsu_done) begin
          len_q <= dsu_quo[RadW-1:0];
          j_q   <= 2'd0;
        end
      end
      ST_MD_WAIT: begin
        if (dsu_done) begin
          case (j_q)
            2'd0:    nox_q <= md_val;
            2'd1:    noy_q <= md_val;
            2'd2:    pux_q <= md_val;
            default: puy_q <= md_val;
          endcase
          j_q <= j_q + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy        = state_q != ST_IDLE;
  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign hit_kind_o  = kind_q;
  assign contact_x_o = cox_q;
  assign contact_y_o = coy_q;
  assign normal_x_o  = nox_q;
  assign normal_y_o  = noy_q;
  assign push_x_o    = pux_q;
  assign push_y_o    = puy_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while a test is running");

  a_hit_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_o == (hit_kind_o != KIND_NONE)))
    else $error("hit flag disagrees with hit kind");

  a_corner_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_kind_o == KIND_CORNER) |-> (push_x_o == '0 && push_y_o == '0))
    else $error("corner hit carries a push-out");

  a_dsu_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dsu_cmd.start |-> !dsu_busy) else $error("divide unit restarted while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted test did not raise busy");
`endif

endmodule

FILE: verif/circle_box_contact_top_test.sv
// Self-checking bench for circle_box_contact_top: directed and random contact
// tests, each result checked against a bit-exact predictor. Uses cbc_pkg.
module circle_box_contact_top_test import cbc_pkg::*;;

  typedef struct {
    logic signed [CoordW-1:0] cx, cy;
    logic        [RadW-1:0]   radius;
    logic signed [CoordW-1:0] vx [4];
    logic signed [CoordW-1:0] vy [4];
    logic                     immovable;
  } contact_test_t;

  typedef struct packed {
    logic                     hit;
    hit_kind_e                kind;
    logic signed [CoordW-1:0] contact_x, contact_y, normal_x, normal_y, push_x, push_y;
  } contact_result_t;

  localparam longint SatMax = 64'sd2147483647;

  function automatic longint sat_sym(longint x);
    if (x > SatMax) return SatMax;
    if (x < -SatMax) return -SatMax;
    return x;
  endfunction

  function automatic longint sat32(longint x);
    if (x > SatMax) return SatMax;
    if (x < -SatMax - 1) return -SatMax - 1;
    return x;
  endfunction

  function automatic longint unsigned mag_of(longint x);
    return x < 0 ? $unsigned(-x) : $unsigned(x);
  endfunction

  function automatic longint unsigned len_sq(longint x, longint y);
    return mag_of(x) * mag_of(x) + mag_of(y) * mag_of(y);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // num * mul / den, rounded half away from zero.
  function automatic longint scaled_quotient(longint num, longint unsigned mul,
                                             longint unsigned den);
    longint unsigned q;
    q = (mag_of(num) * mul + den / 2) / den;
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  // x times a Q1.31 fraction, rounded half away from zero.
  function automatic longint frac_scale(longint x, longint unsigned t);
    longint unsigned q;
    q = (mag_of(x) * t + (64'd1 << 30)) >> 31;
    return x < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic contact_result_t predict_contact(contact_test_t t);
    contact_result_t res;
    longint cx, cy, ex, ey, wx, wy, dot, e2x, e2y, qx, qy, nx, ny, px, py;
    longint vx [4];
    longint vy [4];
    longint unsigned r, r2, l2, frac, rem, len;
    int nk;
    res = '0;
    res.kind = KIND_NONE;
    cx = t.cx;
    cy = t.cy;
    r = t.radius;
    r2 = r * r;
    for (int k = 0; k < 4; k++) begin
      vx[k] = t.vx[k];
      vy[k] = t.vy[k];
    end
    for (int k = 0; k < 4; k++) begin
      nk = (k + 1) % 4;
      ex = sat_sym(vx[nk] - vx[k]);
      ey = sat_sym(vy[nk] - vy[k]);
      wx = sat_sym(cx - vx[k]);
      wy = sat_sym(cy - vy[k]);
      if (len_sq(wx, wy) < r2) begin
        res.hit = 1'b1;
        res.kind = KIND_CORNER;
        res.contact_x = 32'(vx[k]);
        res.contact_y = 32'(vy[k]);
        res.normal_x = 32'(wx);
        res.normal_y = 32'(wy);
        return res;
      end
      l2 = len_sq(ex, ey);
      dot = wx * ex + wy * ey;
      if (dot > 0 && $unsigned(dot) <= l2) begin
        if ($unsigned(dot) >= l2) begin
          frac = 64'd1 << 31;
        end else begin
          rem = $unsigned(dot);
          frac = 0;
          for (int i = 0; i < 31; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= l2) begin
              rem = rem - l2;
              frac = frac | 1;
            end
          end
        end
        e2x = frac_scale(ex, frac);
        e2y = frac_scale(ey, frac);
        qx = sat_sym(wx - e2x);
        qy = sat_sym(wy - e2y);
        if (len_sq(qx, qy) < r2) begin
          len = floor_sqrt(len_sq(qx, qy));
          nx = 0; ny = 0; px = 0; py = 0;
          if (len != 0) begin
            nx = scaled_quotient(qx, 65536, len);
            ny = scaled_quotient(qy, 65536, len);
            if (!t.immovable) begin
              px = scaled_quotient(qx, r - len, len);
              py = scaled_quotient(qy, r - len, len);
            end
          end
          res.hit = 1'b1;
          res.kind = KIND_EDGE;
          res.contact_x = 32'(sat32(vx[k] + e2x));
          res.contact_y = 32'(sat32(vy[k] + e2y));
          res.normal_x = 32'(nx);
          res.normal_y = 32'(ny);
          res.push_x = 32'(px);
          res.push_y = 32'(py);
          return res;
        end
      end
    end
    return res;
  endfunction

  class contact_scoreboard;
    contact_result_t pending_contacts [$];
    int mismatches;

    function void note_test(contact_test_t t);
      pending_contacts.push_back(predict_contact(t));
    endfunction

    function void check_result(contact_result_t got);
      contact_result_t want;
      if (pending_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no test pending: %p", got);
        return;
      end
      want = pending_contacts.pop_front();
      if (got.hit !== want.hit || got.kind !== want.kind ||
          got.contact_x !== want.contact_x || got.contact_y !== want.contact_y ||
          got.normal_x !== want.normal_x || got.normal_y !== want.normal_y ||
          got.push_x !== want.push_x || got.push_y !== want.push_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done_o, hit_o;
  logic [1:0] hit_kind_o;
  logic signed [CoordW-1:0] contact_x_o, contact_y_o, normal_x_o, normal_y_o, push_x_o, push_y_o;
  contact_test_t drv = '{default: '0, vx: '{default: '0}, vy: '{default: '0}};
  contact_scoreboard scoreboard = new();

  always #2 clk_i = ~clk_i;

  circle_box_contact_top i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .center_x_i(drv.cx), .center_y_i(drv.cy), .circle_radius_i(drv.radius),
    .corner0_x_i(drv.vx[0]), .corner0_y_i(drv.vy[0]),
    .corner1_x_i(drv.vx[1]), .corner1_y_i(drv.vy[1]),
    .corner2_x_i(drv.vx[2]), .corner2_y_i(drv.vy[2]),
    .corner3_x_i(drv.vx[3]), .corner3_y_i(drv.vy[3]),
    .circle_immovable_i(drv.immovable),
    .done_o, .hit_o, .hit_kind_o, .contact_x_o, .contact_y_o,
    .normal_x_o, .normal_y_o, .push_x_o, .push_y_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      scoreboard.check_result('{hit_o, hit_kind_e'(hit_kind_o), contact_x_o, contact_y_o,
                                normal_x_o, normal_y_o, push_x_o, push_y_o});
  end

  // Holds start high until the block takes the transfer.
  task automatic send_test(contact_test_t t, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    drv = t;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    scoreboard.note_test(t);
  endtask

  function automatic contact_test_t make_box(int cxo, int cyo, int hw, int hh, int spin);
    contact_test_t t;
    int sx [4] = '{-1, 1, 1, -1};
    int sy [4] = '{-1, -1, 1, 1};
    for (int k = 0; k < 4; k++) begin
      t.vx[k] = cxo + sx[k] * hw - spin * sy[k] * hh / 4;
      t.vy[k] = cyo + sy[k] * hh + spin * sx[k] * hw / 4;
    end
    t.cx = 0; t.cy = 0; t.radius = '0; t.immovable = 1'b0;
    return t;
  endfunction

  function automatic contact_test_t random_test();
    contact_test_t t;
    int unsigned pick = $urandom_range(99);
    int span = 1 << $urandom_range(24, 10);
    if (pick < 15) begin
      t.cx = $urandom; t.cy = $urandom; t.radius = 31'($urandom);
      for (int k = 0; k < 4; k++) begin
        t.vx[k] = $urandom; t.vy[k] = $urandom;
      end
    end else begin
      t = make_box(int'($urandom_range(2 * span)) - span, int'($urandom_range(2 * span)) - span,
                   $urandom_range(span), $urandom_range(span), int'($urandom_range(8)) - 4);
      // A repeated corner gives a degenerate edge.
      if (pick < 20) begin
        t.vx[1] = t.vx[0];
        t.vy[1] = t.vy[0];
      end
      t.cx = int'($urandom_range(6 * span)) - 3 * span;
      t.cy = int'($urandom_range(6 * span)) - 3 * span;
      t.radius = 31'($urandom_range(2 * span));
    end
    t.immovable = 1'($urandom_range(1));
    return t;
  endfunction

  task automatic run_random(int count, int idle_pct);
    repeat (count) send_test(random_test(), idle_pct);
  endtask

  initial begin
    contact_test_t t;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Everything zero: a zero radius never touches.
    t = make_box(0, 0, 0, 0, 0);
    send_test(t, 0);
    // Extremes of every field.
    t.cx = 32'h7fff_ffff; t.cy = 32'h8000_0000; t.radius = 31'h7fff_ffff;
    t.vx = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    t.vy = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
    t.immovable = 1'b1;
    send_test(t, 0);
    t.cx = 32'h8000_0000; t.cy = 32'h7fff_ffff; t.immovable = 1'b0;
    send_test(t, 0);
    t.radius = 31'h1;
    send_test(t, 0);
    // Corner hit, edge hits either way, clear miss.
    t = make_box(0, 0, 32'h10000, 32'h10000, 0);
    t.cx = 32'h12000; t.cy = 32'h12000; t.radius = 31'h8000;
    send_test(t, 0);
    t.cx = 0; t.cy = 32'h18000; t.radius = 31'h10000;
    send_test(t, 0);
    t.immovable = 1'b1;
    send_test(t, 0);
    t.cx = 32'h50000;
    send_test(t, 0);
    // Center exactly on an edge: the offset vector is zero.
    t.cx = 0; t.cy = 32'h10000; t.radius = 31'h8000; t.immovable = 1'b0;
    send_test(t, 0);
    // Projection at the very end of an edge, rotated box.
    t = make_box(32'h3000, -32'h7000, 32'h20000, 32'h8000, 3);
    t.cx = t.vx[1]; t.cy = t.vy[1] - 32'h100; t.radius = 31'h80;
    send_test(t, 0);
    // All corners equal: degenerate everywhere.
    t = make_box(32'h1234, 32'h5678, 0, 0, 0);
    t.cx = 32'h2000; t.cy = 32'h5678; t.radius = 31'h100;
    send_test(t, 0);

    run_random(300, 11);
    run_random(300, 60);
    run_random(300, 0);

    @(negedge clk_i);
    start = 1'b0;
    while (scoreboard.pending_contacts.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (scoreboard.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("tb: failure");
    $finish;
  end
endmodule

FILE: circle_box_contact_top.f
hw/rtl/cbc_pkg.sv
hw/rtl/cbc_mul.sv
hw/rtl/cbc_dsu.sv
hw/rtl/circle_box_contact_top.sv
verif/circle_box_contact_top_test.sv
